// ===== sv/glzw_pkg.sv =====
// ---------------------------------------------------------------------------
// glzw_pkg
// Shared types, constants and helpers for the GIF LZW decoder.
// ---------------------------------------------------------------------------
package glzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
    localparam int TABLE_AW      = MAX_CODE_BITS;
    localparam int NFC_W         = MAX_CODE_BITS + 1;
    localparam int STACK_DEPTH   = 4096;
    localparam int STACK_AW      = $clog2(STACK_DEPTH);
    localparam int STACK_CW      = STACK_AW + 1;
    localparam int BUF_BITS      = 20;
    localparam int BITCNT_W      = 5;
    localparam int CW_W          = 4;
    localparam int FEED_LIMIT    = BUF_BITS - 8;
    localparam int MCS_MIN       = 2;
    localparam int MCS_MAX       = 8;
    localparam logic [3:0] MCS_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_FEED    = 2'd0,
        CMD_FETCH   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK    = 3'd0,
        STS_MORE  = 3'd1,
        STS_END   = 3'd2,
        STS_BAD   = 3'd3,
        STS_FULL  = 3'd4,
        STS_TRUNC = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        DONE_ACTIVE = 2'd0,
        DONE_END    = 2'd1,
        DONE_BAD    = 2'd2,
        DONE_TRUNC  = 2'd3
    } t_done;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POP,
        S_DECODE,
        S_WALK_RD,
        S_WALK_PUSH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] color_index;
    } t_rsp;

    // Commands from controller to datapath
    typedef struct packed {
        logic    feed;
        logic    restart;
        logic    pop;
        logic    take_code;
        logic    init_dict;
        logic    first_code;
        logic    walk_norm;
        logic    walk_kwk;
        logic    walk_read;
        logic    walk_push;
        logic    push_root;
        logic    update;
        logic    stack_clear;
        logic    set_done;
        t_done   done_val;
        logic    resp;
        t_status resp_status;
        logic    resp_color;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_done done;
        logic  buf_full;
        logic  stack_nonempty;
        logic  stack_full;
        logic  bits_short;
        logic  input_ended;
        logic  prev_valid;
        logic  code_is_end;
        logic  code_is_clear;
        logic  code_ge_cc;
        logic  code_gt_nfc;
        logic  code_eq_nfc;
        logic  walk_ge_cc;
    } t_dp_stat;

    function automatic logic [3:0] eff_mcs(input logic [3:0] mcs);
        logic [3:0] res;
        res = mcs;
        if (mcs < 4'(MCS_MIN)) res = 4'(MCS_MIN);
        if (mcs > 4'(MCS_MAX)) res = 4'(MCS_MAX);
        return res;
    endfunction

    function automatic t_status done_status(input t_done d);
        t_status res;
        unique case (d)
            DONE_END: res = STS_END;
            DONE_BAD: res = STS_BAD;
            default:  res = STS_TRUNC;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/glzw_ctrl.sv =====
// ---------------------------------------------------------------------------
// glzw_ctrl
// Sequencer for request handling, code decode and dictionary walk.
// ---------------------------------------------------------------------------
module glzw_ctrl import glzw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_cmd     i_cmd,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_cmd == CMD_FETCH && i_stat.done == DONE_ACTIVE) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.stack_nonempty) n_state = S_POP;
                else if (i_stat.bits_short) n_state = S_IDLE;
                else n_state = S_DECODE;
            end
            S_POP: n_state = S_IDLE;
            S_DECODE: begin
                if (i_stat.code_is_end) n_state = S_IDLE;
                else if (i_stat.code_is_clear) n_state = S_CHECK;
                else if (!i_stat.prev_valid) begin
                    n_state = i_stat.code_ge_cc ? S_IDLE : S_CHECK;
                end else if (i_stat.code_gt_nfc) n_state = S_IDLE;
                else n_state = S_WALK_RD;
            end
            S_WALK_RD: begin
                if (i_stat.walk_ge_cc) n_state = S_WALK_PUSH;
                else if (i_stat.stack_full) n_state = S_IDLE;
                else n_state = S_UPDATE;
            end
            S_WALK_PUSH: n_state = i_stat.stack_full ? S_IDLE : S_WALK_RD;
            S_UPDATE: n_state = S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ctl = '0;
        o_ctl.done_val    = DONE_ACTIVE;
        o_ctl.resp_status = STS_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        CMD_FEED: begin
                            o_ctl.resp = 1'b1;
                            if (i_stat.done != DONE_ACTIVE) begin
                                o_ctl.resp_status = done_status(i_stat.done);
                            end else if (i_stat.buf_full) begin
                                o_ctl.resp_status = STS_FULL;
                            end else begin
                                o_ctl.feed = 1'b1;
                            end
                        end
                        CMD_FETCH: begin
                            if (i_stat.done != DONE_ACTIVE) begin
                                o_ctl.resp        = 1'b1;
                                o_ctl.resp_status = done_status(i_stat.done);
                            end
                        end
                        CMD_RESTART: begin
                            o_ctl.restart = 1'b1;
                            o_ctl.resp    = 1'b1;
                        end
                        CMD_NONE: o_ctl.resp = 1'b1;
                        default: o_ctl.resp = 1'b1;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_stat.stack_nonempty) begin
                    o_ctl.pop = 1'b1;
                end else if (i_stat.bits_short) begin
                    o_ctl.resp = 1'b1;
                    if (i_stat.input_ended) begin
                        o_ctl.set_done    = 1'b1;
                        o_ctl.done_val    = DONE_TRUNC;
                        o_ctl.resp_status = STS_TRUNC;
                    end else begin
                        o_ctl.resp_status = STS_MORE;
                    end
                end else begin
                    o_ctl.take_code = 1'b1;
                end
            end
            S_POP: begin
                o_ctl.resp       = 1'b1;
                o_ctl.resp_color = 1'b1;
            end
            S_DECODE: begin
                if (i_stat.code_is_end) begin
                    o_ctl.set_done    = 1'b1;
                    o_ctl.done_val    = DONE_END;
                    o_ctl.resp        = 1'b1;
                    o_ctl.resp_status = STS_END;
                end else if (i_stat.code_is_clear) begin
                    o_ctl.init_dict = 1'b1;
                end else if (!i_stat.prev_valid) begin
                    if (i_stat.code_ge_cc) begin
                        o_ctl.set_done    = 1'b1;
                        o_ctl.done_val    = DONE_BAD;
                        o_ctl.resp        = 1'b1;
                        o_ctl.resp_status = STS_BAD;
                    end else begin
                        o_ctl.first_code = 1'b1;
                    end
                end else if (i_stat.code_gt_nfc) begin
                    o_ctl.set_done    = 1'b1;
                    o_ctl.done_val    = DONE_BAD;
                    o_ctl.resp        = 1'b1;
                    o_ctl.resp_status = STS_BAD;
                end else if (i_stat.code_eq_nfc) begin
                    o_ctl.walk_kwk = 1'b1;
                end else begin
                    o_ctl.walk_norm = 1'b1;
                end
            end
            S_WALK_RD: begin
                if (i_stat.walk_ge_cc) begin
                    o_ctl.walk_read = 1'b1;
                end else if (i_stat.stack_full) begin
                    o_ctl.stack_clear = 1'b1;
                    o_ctl.set_done    = 1'b1;
                    o_ctl.done_val    = DONE_BAD;
                    o_ctl.resp        = 1'b1;
                    o_ctl.resp_status = STS_BAD;
                end else begin
                    o_ctl.push_root = 1'b1;
                end
            end
            S_WALK_PUSH: begin
                if (i_stat.stack_full) begin
                    o_ctl.stack_clear = 1'b1;
                    o_ctl.set_done    = 1'b1;
                    o_ctl.done_val    = DONE_BAD;
                    o_ctl.resp        = 1'b1;
                    o_ctl.resp_status = STS_BAD;
                end else begin
                    o_ctl.walk_push = 1'b1;
                end
            end
            S_UPDATE: o_ctl.update = 1'b1;
            default: o_ctl = '0;
        endcase
    end

endmodule

// ===== sv/glzw_dpath.sv =====
// ---------------------------------------------------------------------------
// glzw_dpath
// Bit buffer, dictionary tables, string stack and response register.
// ---------------------------------------------------------------------------
module glzw_dpath import glzw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  t_dp_cmd    i_ctl,
    output t_dp_stat   o_stat,
    output t_rsp       o_rsp,
    output logic       o_rsp_strobe
);

    logic [7:0]  r_suffix_mem [TABLE_SIZE];
    logic [MAX_CODE_BITS-1:0] r_prefix_hi [TABLE_SIZE];
    logic [7:0]  r_stack_mem  [STACK_DEPTH];

    logic [3:0]               r_mcs;
    logic [BUF_BITS-1:0]      r_buf;
    logic [BITCNT_W-1:0]      r_bitcnt;
    logic [CW_W-1:0]          r_cw;
    logic [NFC_W-1:0]         r_nfc;
    logic [MAX_CODE_BITS-1:0] r_prev;
    logic                     r_prev_valid;
    logic [7:0]               r_prev_first;
    logic                     r_ended;
    t_done                    r_done;
    logic [STACK_CW-1:0]      r_cnt;
    logic                     r_strobe;

    logic [MAX_CODE_BITS-1:0] r_code;
    logic [MAX_CODE_BITS-1:0] r_walk;
    logic                     r_kwk;
    logic [7:0]               r_first;
    logic [MAX_CODE_BITS-1:0] r_pfx_rd;
    logic [7:0]               r_sfx_rd;
    logic [7:0]               r_stack_rd;
    t_rsp                     r_rsp;

    logic [3:0]               w_eff;
    logic [3:0]               w_cfg_eff;
    logic [NFC_W-1:0]         w_cc;
    logic [NFC_W-1:0]         w_cfg_cc;
    logic [NFC_W-1:0]         w_code13;
    logic [NFC_W-1:0]         w_walk13;
    logic [BUF_BITS-1:0]      w_mask;
    logic [BUF_BITS+7:0]      w_feed_sh;
    logic [NFC_W-1:0]         n_nfc;
    logic                     w_push;
    logic [7:0]               w_push_val;

    assign w_eff     = eff_mcs(r_mcs);
    assign w_cfg_eff = eff_mcs(i_cfg_wdata);
    assign w_cc      = NFC_W'(1) << w_eff;
    assign w_cfg_cc  = NFC_W'(1) << w_cfg_eff;
    assign w_code13  = {1'b0, r_code};
    assign w_walk13  = {1'b0, r_walk};
    assign w_mask    = ~({BUF_BITS{1'b1}} << r_cw);
    assign w_feed_sh = (BUF_BITS+8)'(i_req.data_byte) << r_bitcnt;
    assign n_nfc     = r_nfc + NFC_W'(1);

    always_comb begin
        w_push     = 1'b0;
        w_push_val = r_sfx_rd;
        if (i_ctl.first_code) begin
            w_push     = 1'b1;
            w_push_val = r_code[7:0];
        end else if (i_ctl.walk_kwk) begin
            w_push     = 1'b1;
            w_push_val = r_prev_first;
        end else if (i_ctl.push_root) begin
            w_push     = 1'b1;
            w_push_val = r_walk[7:0];
        end else if (i_ctl.walk_push) begin
            w_push     = 1'b1;
            w_push_val = r_sfx_rd;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat.done           = r_done;
        o_stat.buf_full       = (r_bitcnt > BITCNT_W'(FEED_LIMIT));
        o_stat.stack_nonempty = (r_cnt != '0);
        o_stat.stack_full     = (r_cnt == STACK_CW'(STACK_DEPTH));
        o_stat.bits_short     = ({1'b0, r_bitcnt} < (BITCNT_W+1)'(r_cw));
        o_stat.input_ended    = r_ended;
        o_stat.prev_valid     = r_prev_valid;
        o_stat.code_is_end    = (w_code13 == w_cc + NFC_W'(1));
        o_stat.code_is_clear  = (w_code13 == w_cc);
        o_stat.code_ge_cc     = (w_code13 >= w_cc);
        o_stat.code_gt_nfc    = (w_code13 > r_nfc);
        o_stat.code_eq_nfc    = (w_code13 == r_nfc);
        o_stat.walk_ge_cc     = (w_walk13 >= w_cc);
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcs        <= MCS_RESET;
            r_buf        <= '0;
            r_bitcnt     <= '0;
            r_cw         <= MCS_RESET + 4'd1;
            r_nfc        <= (NFC_W'(1) << MCS_RESET) + NFC_W'(2);
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_prev_first <= '0;
            r_ended      <= 1'b0;
            r_done       <= DONE_ACTIVE;
            r_cnt        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= i_ctl.resp;
            if (i_cfg_we || i_ctl.restart) begin
                if (i_cfg_we) begin
                    r_mcs <= i_cfg_wdata;
                    r_cw  <= w_cfg_eff + 4'd1;
                    r_nfc <= w_cfg_cc + NFC_W'(2);
                end else begin
                    r_cw  <= w_eff + 4'd1;
                    r_nfc <= w_cc + NFC_W'(2);
                end
                r_buf        <= '0;
                r_bitcnt     <= '0;
                r_prev       <= '0;
                r_prev_valid <= 1'b0;
                r_ended      <= 1'b0;
                r_done       <= DONE_ACTIVE;
                r_cnt        <= '0;
            end else begin
                if (i_ctl.feed) begin
                    r_buf    <= r_buf | w_feed_sh[BUF_BITS-1:0];
                    r_bitcnt <= r_bitcnt + BITCNT_W'(8);
                    if (i_req.last_byte) r_ended <= 1'b1;
                end
                if (i_ctl.take_code) begin
                    r_buf    <= r_buf >> r_cw;
                    r_bitcnt <= r_bitcnt - BITCNT_W'(r_cw);
                end
                if (i_ctl.init_dict) begin
                    r_cw         <= w_eff + 4'd1;
                    r_nfc        <= w_cc + NFC_W'(2);
                    r_prev_valid <= 1'b0;
                end
                if (i_ctl.first_code) begin
                    r_prev       <= r_code;
                    r_prev_valid <= 1'b1;
                    r_prev_first <= r_code[7:0];
                end
                if (i_ctl.update) begin
                    if (r_nfc < NFC_W'(TABLE_SIZE)) begin
                        r_nfc <= n_nfc;
                        if (n_nfc == (NFC_W'(1) << r_cw) && r_cw < CW_W'(MAX_CODE_BITS)) begin
                            r_cw <= r_cw + CW_W'(1);
                        end
                    end
                    r_prev       <= r_code;
                    r_prev_first <= r_first;
                end
                if (i_ctl.set_done) r_done <= i_ctl.done_val;
                if (i_ctl.stack_clear) begin
                    r_cnt <= '0;
                end else if (i_ctl.pop) begin
                    r_cnt <= r_cnt - STACK_CW'(1);
                end else if (w_push) begin
                    r_cnt <= r_cnt + STACK_CW'(1);
                end
            end
        end
    end

    // Walk registers and response payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_code) begin
            r_code <= r_buf[MAX_CODE_BITS-1:0] & w_mask[MAX_CODE_BITS-1:0];
        end
        if (i_ctl.walk_norm) begin
            r_walk <= r_code;
            r_kwk  <= 1'b0;
        end
        if (i_ctl.walk_kwk) begin
            r_walk  <= r_prev;
            r_kwk   <= 1'b1;
            r_first <= r_prev_first;
        end
        if (i_ctl.walk_push) r_walk <= r_pfx_rd;
        if (i_ctl.push_root && !r_kwk) r_first <= r_walk[7:0];
        if (i_ctl.resp) begin
            r_rsp.status      <= i_ctl.resp_status;
            r_rsp.color_index <= i_ctl.resp_color ? r_stack_rd : 8'd0;
        end
    end

    // Dictionary tables
    always_ff @(posedge i_clk) begin
        if (i_ctl.update && r_nfc < NFC_W'(TABLE_SIZE)) begin
            r_prefix_hi[r_nfc[TABLE_AW-1:0]]  <= r_prev;
            r_suffix_mem[r_nfc[TABLE_AW-1:0]] <= r_first;
        end
        if (i_ctl.walk_read) begin
            r_pfx_rd <= r_prefix_hi[r_walk[TABLE_AW-1:0]];
            r_sfx_rd <= r_suffix_mem[r_walk[TABLE_AW-1:0]];
        end
    end

    // String stack
    always_ff @(posedge i_clk) begin
        if (w_push && !i_ctl.stack_clear) begin
            r_stack_mem[r_cnt[STACK_AW-1:0]] <= w_push_val;
        end
        if (i_ctl.pop) begin
            r_stack_rd <= r_stack_mem[r_cnt[STACK_AW-1:0] - STACK_AW'(1)];
        end
    end

    assign o_rsp        = r_rsp;
    assign o_rsp_strobe = r_strobe;

endmodule

// ===== sv/gif_lzw_decoder_top.sv =====
// ---------------------------------------------------------------------------
// gif_lzw_decoder_top
// GIF LZW decompressor, 12-bit variable code width, one color index per fetch.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one response, shown on o_rsp for one cycle with o_rsp_strobe high,
// and the receiver cannot stall it. Feed, restart and idle requests, and any
// request after decoding has stopped, answer in the cycle after acceptance
// without raising busy. A fetch that finds a stacked character is answered
// from the stack: the check state reads it and the pop state answers. A fetch
// that must decode a new code walks its string: each character above the root
// costs one registered read of the prefix/suffix tables, every character costs
// one stack push, and the string is then popped as above; a clear code resets
// the dictionary first. Writing min_code_size restarts the decoder in the same cycle.
// ---------------------------------------------------------------------------
module gif_lzw_decoder_top import glzw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    output t_rsp       o_rsp,
    output logic       o_rsp_strobe
);

    t_dp_cmd  w_ctl;
    t_dp_stat w_stat;
    t_cmd     w_cmd;

    // Map the request command onto its code; all four codes are meaningful
    assign w_cmd = t_cmd'(i_req.cmd);

    // Sequence the request: dispatch, decode codes, walk the dictionary
    glzw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (w_cmd),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    // Hold the bit buffer, tables, stack and the response register
    glzw_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_ctl        (w_ctl),
        .o_stat       (w_stat),
        .o_rsp        (o_rsp),
        .o_rsp_strobe (o_rsp_strobe)
    );

    // A response only follows an accepted request or a busy cycle
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_strobe |-> ($past(start && !busy) || $past(busy)))
        else $error("response without a request in flight");

    // Leaving busy always delivers the response of that request
    a_busy_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_rsp_strobe)
        else $error("request finished without a response");

    // Only a successful fetch carries a color index
    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_strobe && o_rsp.status != STS_OK) |-> (o_rsp.color_index == 8'd0))
        else $error("color index set on a non-ok response");

    // A pop while the stack count is full must see a nonempty stack
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.stack_full |-> !w_ctl.pop || w_stat.stack_nonempty)
        else $error("stack pop with inconsistent count");

endmodule

// ===== verif/tb_gif_lzw_decoder_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_gif_lzw_decoder_top
// Self-checking bench for the GIF LZW decoder: builds LZW code streams,
// feeds and fetches them through the request port, and checks every response
// against a cycle-free model of the decoder.
// ---------------------------------------------------------------------------
module tb_gif_lzw_decoder_top;
    import glzw_pkg::*;

    localparam int IDLE_PCT      = 17;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 4000000;

    typedef enum int {
        IMG_CLEAN,
        IMG_TRUNC,
        IMG_BAD,
        IMG_OPEN
    } t_img_kind;

    // -----------------------------------------------------------------------
    // DUT connections
    // -----------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       req_d;
    logic       i_cfg_we;
    logic [3:0] i_cfg_wdata;
    t_rsp       rsp_w;
    logic       rsp_strobe;

    gif_lzw_decoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (req_d),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_rsp        (rsp_w),
        .o_rsp_strobe (rsp_strobe)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Decoder model state: its own copy of the register and the dictionary
    // -----------------------------------------------------------------------
    logic [3:0]  mcs_reg;
    logic [11:0] pfx_tab [TABLE_SIZE];
    logic [7:0]  sfx_tab [TABLE_SIZE];
    logic [7:0]  chr_stack [STACK_DEPTH];
    int unsigned stk_cnt;
    int unsigned bbuf;
    int unsigned bcnt;
    int unsigned cwidth;
    int unsigned nfc;
    int unsigned prev_code;
    bit          prev_ok;
    bit          in_ended;
    t_done       pdone;

    // Responses still owed by the decoder, oldest first
    t_rsp        decoded_rsp_q [$];

    int          mismatch_cnt = 0;
    int          item_cnt = 0;
    int          idle_pct = IDLE_PCT;
    t_status     last_st = STS_OK;

    // Code stream under construction and the encoder-side view of the table
    logic [7:0]  img_bytes [$];
    logic [63:0] pack_acc;
    int          pack_n;
    int unsigned trk_mcs;
    int unsigned trk_cc;
    int unsigned trk_nfc;
    int unsigned trk_w;
    bit          trk_pv;

    // -----------------------------------------------------------------------
    // Decoder model
    // -----------------------------------------------------------------------
    // Clamp the register to the legal code sizes
    function automatic int unsigned size_eff(logic [3:0] v);
        if (v < 4'd2) return 2;
        if (v > 4'd8) return 8;
        return 32'(v);
    endfunction

    function automatic int unsigned clear_code_of();
        return 32'd1 << size_eff(mcs_reg);
    endfunction

    function automatic void reset_dict();
        cwidth  = size_eff(mcs_reg) + 1;
        nfc     = clear_code_of() + 2;
        prev_ok = 1'b0;
    endfunction

    function automatic void dict_restart();
        stk_cnt   = 0;
        bbuf      = 0;
        bcnt      = 0;
        prev_code = 0;
        in_ended  = 1'b0;
        pdone     = DONE_ACTIVE;
        reset_dict();
    endfunction

    function automatic t_status stopped_status();
        if (pdone == DONE_END) return STS_END;
        if (pdone == DONE_BAD) return STS_BAD;
        return STS_TRUNC;
    endfunction

    function automatic bit push_chr(int unsigned c);
        if (stk_cnt >= STACK_DEPTH) return 1'b0;
        chr_stack[stk_cnt] = c[7:0];
        stk_cnt++;
        return 1'b1;
    endfunction

    // First character of the string behind code c
    function automatic int unsigned root_chr(int unsigned c);
        int unsigned cc;
        cc = clear_code_of();
        for (int g = 0; g < TABLE_SIZE && c >= cc; g++)
            c = pfx_tab[c % TABLE_SIZE];
        return c & 32'hFF;
    endfunction

    // Stack the string behind code c, last character first
    function automatic bit push_chain(int unsigned c);
        int unsigned cc;
        cc = clear_code_of();
        for (int g = 0; g < TABLE_SIZE && c >= cc; g++) begin
            if (!push_chr(sfx_tab[c % TABLE_SIZE])) return 1'b0;
            c = pfx_tab[c % TABLE_SIZE];
        end
        return push_chr(c);
    endfunction

    // One fetch: pop a stacked character, or pull codes until one gives output
    task automatic decode_fetch(output t_status st, output logic [7:0] col);
        int unsigned cc;
        int unsigned code;
        int unsigned root;
        bit          ok;
        col = '0;
        if (pdone != DONE_ACTIVE) begin
            st = stopped_status();
            return;
        end
        cc = clear_code_of();
        forever begin
            if (stk_cnt > 0) begin
                stk_cnt--;
                col = chr_stack[stk_cnt];
                st  = STS_OK;
                return;
            end
            if (bcnt < cwidth) begin
                if (in_ended) begin
                    pdone = DONE_TRUNC;
                    st    = STS_TRUNC;
                end else begin
                    st = STS_MORE;
                end
                return;
            end
            code = bbuf & ((32'd1 << cwidth) - 1);
            bbuf = bbuf >> cwidth;
            bcnt = bcnt - cwidth;
            if (code == cc + 1) begin
                pdone = DONE_END;
                st    = STS_END;
                return;
            end
            if (code == cc) begin
                reset_dict();
                continue;
            end
            if (!prev_ok) begin
                if (code >= cc) begin
                    pdone = DONE_BAD;
                    st    = STS_BAD;
                    return;
                end
                ok        = push_chr(code);
                prev_code = code;
                prev_ok   = 1'b1;
                continue;
            end
            if (code > nfc) begin
                pdone = DONE_BAD;
                st    = STS_BAD;
                return;
            end
            if (code < nfc) begin
                ok   = push_chain(code);
                root = root_chr(code);
            end else begin
                // Code not yet in the table: previous string plus its own head
                root = root_chr(prev_code);
                ok   = push_chr(root);
                if (ok) ok = push_chain(prev_code);
            end
            if (!ok) begin
                stk_cnt = 0;
                pdone   = DONE_BAD;
                st      = STS_BAD;
                return;
            end
            if (nfc < TABLE_SIZE) begin
                pfx_tab[nfc] = prev_code[11:0];
                sfx_tab[nfc] = root[7:0];
                nfc++;
                if (nfc == (32'd1 << cwidth) && cwidth < MAX_CODE_BITS) cwidth++;
            end
            prev_code = code;
        end
    endtask

    task automatic lzw_predict(input t_req r, output t_rsp e);
        t_status    st;
        logic [7:0] col;
        st  = STS_OK;
        col = '0;
        case (r.cmd)
            CMD_FEED: begin
                if (pdone != DONE_ACTIVE) begin
                    st = stopped_status();
                end else if (bcnt + 8 > BUF_BITS) begin
                    st = STS_FULL;
                end else begin
                    bbuf = (bbuf | (32'(r.data_byte) << bcnt)) & ((32'd1 << BUF_BITS) - 1);
                    bcnt = bcnt + 8;
                    if (r.last_byte) in_ended = 1'b1;
                end
            end
            CMD_FETCH: begin
                decode_fetch(st, col);
                if (st != STS_OK) col = '0;
            end
            CMD_RESTART: dict_restart();
            default: ;
        endcase
        e.status      = st;
        e.color_index = col;
    endtask

    // -----------------------------------------------------------------------
    // Request driver
    // -----------------------------------------------------------------------
    // Send one request: idle a random gap, hold start until busy is low at
    // an edge, then predict the response of the accepted request.
    task automatic send_req(input logic [1:0] cmd_v, input logic [7:0] data_v,
                            input logic last_v);
        t_req r;
        t_rsp e;
        int   gap;
        r.cmd       = cmd_v;
        r.data_byte = data_v;
        r.last_byte = last_v;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        // Keep start high across back-to-back requests; lower it only for a gap
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        req_d <= r;
        do @(posedge i_clk); while (busy);
        lzw_predict(r, e);
        decoded_rsp_q = {decoded_rsp_q, e};
        last_st = t_status'(e.status);
        item_cnt++;
    endtask

    // Drop start and wait until every owed response has come back
    task automatic drain_responses();
        start <= 1'b0;
        while (decoded_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the code size only while the decoder is idle; this also restarts it
    task automatic write_min_code_size(input logic [3:0] v);
        drain_responses();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mcs_reg = v;
        dict_restart();
    endtask

    // -----------------------------------------------------------------------
    // Response checker: one strobe, one owed response, compared per field
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_strobe) begin
            if (decoded_rsp_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected response: status %0d color %0d",
                             rsp_w.status, rsp_w.color_index);
            end else begin
                want = decoded_rsp_q.pop_front();
                if (rsp_w.status !== want.status ||
                    rsp_w.color_index !== want.color_index) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("mismatch: expected status %0d color %0d, got status %0d color %0d",
                                 want.status, want.color_index,
                                 rsp_w.status, rsp_w.color_index);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Code stream builder: packs codes LSB first and tracks the code width
    // the decoder will use for each of them
    // -----------------------------------------------------------------------
    task automatic start_image();
        trk_mcs = size_eff(mcs_reg);
        trk_cc  = 32'd1 << trk_mcs;
        trk_nfc = trk_cc + 2;
        trk_w   = trk_mcs + 1;
        trk_pv  = 1'b0;
        img_bytes.delete();
        pack_acc = '0;
        pack_n   = 0;
    endtask

    task automatic emit_code(input int unsigned c);
        pack_acc = pack_acc | (64'(c) << pack_n);
        pack_n   = pack_n + trk_w;
        while (pack_n >= 8) begin
            img_bytes = {img_bytes, pack_acc[7:0]};
            pack_acc  = pack_acc >> 8;
            pack_n    = pack_n - 8;
        end
        if (c == trk_cc) begin
            trk_nfc = trk_cc + 2;
            trk_w   = trk_mcs + 1;
            trk_pv  = 1'b0;
        end else if (c == trk_cc + 1) begin
            // end of data: nothing to track
        end else if (!trk_pv) begin
            trk_pv = 1'b1;
        end else if (trk_nfc < TABLE_SIZE) begin
            trk_nfc++;
            if (trk_nfc == (32'd1 << trk_w) && trk_w < MAX_CODE_BITS) trk_w++;
        end
    endtask

    // Flush the tail byte, padding above the last code with random bits
    task automatic finish_image();
        if (pack_n > 0)
            img_bytes = {img_bytes, pack_acc[7:0] | (8'($urandom) << pack_n)};
    endtask

    // Choose a legal next code: clear, literal, table entry or KwKwK
    function automatic int unsigned pick_code(int kwk_pct, int clr_pct, int ent_pct,
                                              bit recent);
        int          r;
        int unsigned lo;
        r = $urandom_range(99);
        if (r < clr_pct) return trk_cc;
        if (!trk_pv) return $urandom_range(trk_cc - 1, 0);
        r = $urandom_range(99);
        if (r < kwk_pct && trk_nfc < TABLE_SIZE) return trk_nfc;
        if (r < kwk_pct + ent_pct && trk_nfc > trk_cc + 2) begin
            lo = trk_cc + 2;
            if (recent && trk_nfc > lo + 16) lo = trk_nfc - 16;
            return $urandom_range(trk_nfc - 1, lo);
        end
        return $urandom_range(trk_cc - 1, 0);
    endfunction

    task automatic build_image(input t_img_kind kind, input int n_codes);
        bit bad_sent;
        int bad_at;
        start_image();
        bad_sent = 1'b0;
        bad_at   = $urandom_range(n_codes - 1, 0);
        if ($urandom_range(1)) emit_code(trk_cc);
        for (int i = 0; i < n_codes && !bad_sent; i++) begin
            if (kind == IMG_BAD && i >= bad_at) begin
                // Inject a code the decoder cannot know yet
                if (!trk_pv) begin
                    emit_code($urandom_range((32'd1 << trk_w) - 1, trk_cc + 2));
                    bad_sent = 1'b1;
                end else if (trk_nfc + 1 < (32'd1 << trk_w)) begin
                    emit_code($urandom_range((32'd1 << trk_w) - 1, trk_nfc + 1));
                    bad_sent = 1'b1;
                end
            end
            if (!bad_sent) emit_code(pick_code(8, 4, 45, 1'b0));
        end
        if (!bad_sent) emit_code(trk_cc + 1);
        finish_image();
    endtask

    // Push one image through: feed bytes as room allows, fetch in between,
    // and poke the decoder with one more fetch and one more feed after it stops.
    task automatic run_image(input int last_pos);
        int p;
        int stalls;
        p      = 0;
        stalls = 0;
        while (stalls < 3) begin
            if (pdone != DONE_ACTIVE) begin
                send_req(CMD_FETCH, 8'($urandom), 1'($urandom_range(1)));
                send_req(CMD_FEED, 8'($urandom), 1'($urandom_range(1)));
                break;
            end
            if (p < img_bytes.size() && (last_st == STS_MORE || $urandom_range(99) < 40)) begin
                send_req(CMD_FEED, img_bytes[p], p == last_pos);
                // A refused byte is sent again later
                if (last_st == STS_OK) p++;
            end else begin
                send_req(CMD_FETCH, 8'($urandom), 1'($urandom_range(1)));
                if (last_st == STS_MORE && p >= img_bytes.size()) stalls++;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Fetch from an empty decoder, an idle (none) command, and a restart
    task automatic test_idle_commands();
        send_req(CMD_FETCH, 8'h00, 1'b0);
        send_req(CMD_NONE, 8'hFF, 1'b1);
        send_req(CMD_RESTART, 8'hA5, 1'b0);
    endtask

    // Short image at the smallest code size: clear, literal, KwKwK, a second
    // literal, width growth to four bits, a table entry, then end of data
    task automatic test_small_image();
        write_min_code_size(4'd2);
        start_image();
        emit_code(trk_cc);
        emit_code(1);
        emit_code(trk_nfc);
        emit_code(0);
        emit_code(7);
        emit_code(trk_cc + 1);
        finish_image();
        run_image(img_bytes.size() - 1);
    endtask

    // Third byte does not fit once 16 bits are waiting
    task automatic test_buffer_full();
        write_min_code_size(4'd2);
        send_req(CMD_FEED, 8'h00, 1'b0);
        send_req(CMD_FEED, 8'h00, 1'b0);
        send_req(CMD_FEED, 8'hFF, 1'b0);
    endtask

    // Clear and one literal, then two stray bits after the final byte
    task automatic test_truncated_data();
        write_min_code_size(4'd2);
        send_req(CMD_FEED, 8'h0C, 1'b1);
        send_req(CMD_FETCH, 8'h00, 1'b0);
        send_req(CMD_FETCH, 8'h00, 1'b0);
        send_req(CMD_FETCH, 8'h00, 1'b0);
    endtask

    // First code above the end code with no previous code
    task automatic test_bad_first_code();
        write_min_code_size(4'd2);
        send_req(CMD_FEED, 8'h06, 1'b0);
        send_req(CMD_FETCH, 8'h00, 1'b0);
    endtask

    task automatic test_random_images();
        int         first_item;
        int         img_no;
        int         r;
        int         last_pos;
        int         keep;
        logic [3:0] mcs_v;
        t_img_kind  kind;
        first_item = item_cnt;
        img_no     = 0;
        while (item_cnt - first_item < RANDOM_ITEMS) begin
            // Hold a long stretch with no gaps at all
            idle_pct = (img_no >= 6 && img_no < 14) ? 0 : IDLE_PCT;
            if ($urandom_range(99) < 60) begin
                case ($urandom_range(3))
                    0:       mcs_v = 4'd2;
                    1:       mcs_v = 4'd8;
                    default: mcs_v = 4'($urandom_range(15));
                endcase
                write_min_code_size(mcs_v);
            end else begin
                send_req(CMD_RESTART, 8'($urandom), 1'($urandom_range(1)));
            end
            r = $urandom_range(99);
            if (r < 65)      kind = IMG_CLEAN;
            else if (r < 78) kind = IMG_TRUNC;
            else if (r < 90) kind = IMG_BAD;
            else             kind = IMG_OPEN;
            build_image(kind, $urandom_range(40, 3));
            last_pos = img_bytes.size() - 1;
            if (kind == IMG_CLEAN && $urandom_range(99) < 10) begin
                // Mark an early byte as last; later bytes must still be taken
                last_pos = $urandom_range(img_bytes.size() - 1, 0);
            end else if (kind == IMG_TRUNC && img_bytes.size() > 1) begin
                keep      = $urandom_range(img_bytes.size() - 1, 1);
                img_bytes = img_bytes[0:keep-1];
                last_pos  = keep - 1;
            end else if (kind == IMG_OPEN) begin
                last_pos = -1;
            end
            run_image(last_pos);
            // Noise: any command, any byte, either last flag
            if ($urandom_range(99) < 12)
                repeat ($urandom_range(10, 3))
                    send_req(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
            img_no++;
        end
        idle_pct = IDLE_PCT;
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        req_d       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        mcs_reg = MCS_RESET;
        dict_restart();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_commands();
        test_small_image();
        test_buffer_full();
        test_truncated_data();
        test_bad_first_code();
        test_random_images();

        drain_responses();
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop in case the decoder hangs
    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/glzw_pkg.sv
sv/glzw_ctrl.sv
sv/glzw_dpath.sv
sv/gif_lzw_decoder_top.sv
verif/tb_gif_lzw_decoder_top.sv
